// ===== rtl/fbrop_pkg.sv =====
// Package for the frame store raster-op block: request codes, raster ops,
// queue entry and result types. No dependencies.
package fbrop_pkg;

	localparam logic [1:0] REQ_DRAW = 2'd0;
	localparam logic [1:0] REQ_TAKE = 2'd1;
	localparam logic [1:0] REQ_READ = 2'd2;
	localparam logic [1:0] REQ_NONE = 2'd3;

	localparam logic [1:0] ROP_REPLACE = 2'd0;
	localparam logic [1:0] ROP_OR      = 2'd1;
	localparam logic [1:0] ROP_ANDNOT  = 2'd2;
	localparam logic [1:0] ROP_XOR     = 2'd3;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  col;
		logic [6:0]  row;
		logic [6:0]  length;
		logic [63:0] pixels;
		logic [1:0]  rop;
		logic [2:0]  page;
	} req_t;

	// Classified request handed from front to back.
	typedef struct packed {
		logic [1:0]  kind;     // request code, REQ_DRAW, REQ_TAKE, REQ_READ or REQ_NONE
		logic        bad;      // draw rejected or read out of range / no-op
		logic [7:0]  col;
		logic [2:0]  page;
		logic [1:0]  rop;
		logic [63:0] mask;     // bit mask over frame column, row aligned
		logic [63:0] bits;
	} cmd_t;

	typedef struct packed {
		logic       status;
		logic       run_found;
		logic [6:0] run_left;
		logic [6:0] run_right;
		logic [2:0] page_top;
		logic [2:0] page_bottom;
		logic [7:0] read_byte;
	} res_t;

endpackage

// ===== rtl/fbrop_if.sv =====
// Valid/ready channel interface for requests and results.
// Depends on fbrop_pkg types via the type parameter.
interface fbrop_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/fbrop_front.sv =====
// Front part: accepts requests, checks range, builds aligned masks.
// Depends on fbrop_pkg.
module fbrop_front #(
	parameter int WIDTH  = 128,
	parameter int HEIGHT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  fbrop_pkg::req_t   in_data,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output fbrop_pkg::cmd_t   cmd_data
);
	localparam int PAGES = (HEIGHT + 7) / 8;
	fbrop_pkg::cmd_t c;
	logic [63:0] lenmask;
	logic [7:0]  endrow;

	always_comb begin
		lenmask = (in_data.length >= 7'd64) ? {64{1'b1}} :
			((64'd1 << in_data.length[5:0]) - 64'd1);
		endrow = {1'b0, in_data.row} + {1'b0, in_data.length};
		c = '0;
		c.kind = in_data.req_type;
		c.col = in_data.col;
		c.page = in_data.page;
		c.rop = in_data.rop;
		c.mask = lenmask << in_data.row[5:0];
		c.bits = (in_data.pixels & lenmask) << in_data.row[5:0];
		case (in_data.req_type)
			fbrop_pkg::REQ_DRAW: c.bad = ({1'b0, in_data.col} >= 9'(WIDTH)) ||
				(endrow > 8'(HEIGHT));
			fbrop_pkg::REQ_READ: c.bad = ({1'b0, in_data.col} >= 9'(WIDTH)) ||
				({1'b0, in_data.page} >= 4'(PAGES));
			fbrop_pkg::REQ_TAKE: c.bad = 1'b0;
			default: c.bad = 1'b1;
		endcase
	end

	// two-entry queue
	fbrop_pkg::cmd_t q_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	assign in_ready = cnt_q != 2'd2;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd_data = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) q_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wp_q <= ~wp_q;
			if (cmd_valid && cmd_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(cmd_valid && cmd_ready);
		end
	end
endmodule

// ===== rtl/fbrop_back.sv =====
// Back part: frame store and dirty mask memories, clear sweep, draw
// read-modify-write, dirty run search, read. Depends on fbrop_pkg.
module fbrop_back #(
	parameter int WIDTH  = 128,
	parameter int HEIGHT = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  fbrop_pkg::cmd_t  cmd_data,
	output logic             res_valid,
	input  logic             res_ready,
	output fbrop_pkg::res_t  res_data
);
	localparam int PAGES = (HEIGHT + 7) / 8;
	localparam int CW = $clog2(WIDTH);
	localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int AW = CW + PW;

	typedef enum logic [9:0] {
		S_CLR   = 10'b0000000001,
		S_IDLE  = 10'b0000000010,
		S_RD    = 10'b0000000100,
		S_WR    = 10'b0000001000,
		S_SCAN  = 10'b0000010000,
		S_SWAIT = 10'b0000100000,
		S_RUN   = 10'b0001000000,
		S_BYTE  = 10'b0010000000,
		S_RDAT  = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	state_t st_q;
	logic [7:0] fs_mem [2**AW];
	logic [7:0] dm_mem [2**CW];
	logic [7:0] fs_rd_q, dm_rd_q;
	logic [AW-1:0] clr_q;
	fbrop_pkg::cmd_t cmd_q;
	logic [PW-1:0] pg_q;
	logic [CW:0] c_q;
	logic [CW-1:0] left_q;
	logic [7:0] uni_q, dacc_q;
	fbrop_pkg::res_t res_q;

	logic [7:0] m8, b8, nw;
	logic [AW-1:0] addr;
	logic [CW-1:0] cidx;
	assign m8 = 8'(cmd_q.mask >> {pg_q, 3'b000});
	assign b8 = 8'(cmd_q.bits >> {pg_q, 3'b000});
	assign cidx = cmd_q.col[CW-1:0];
	assign addr = {pg_q, cidx};

	always_comb begin
		case (cmd_q.rop)
			fbrop_pkg::ROP_REPLACE: nw = (fs_rd_q & ~m8) | b8;
			fbrop_pkg::ROP_OR:      nw = fs_rd_q | b8;
			fbrop_pkg::ROP_ANDNOT:  nw = fs_rd_q & ~b8;
			default:                nw = fs_rd_q ^ b8;
		endcase
	end

	function automatic logic [2:0] lo1(input logic [7:0] v);
		logic [2:0] r;
		r = 3'd7;
		for (int i = 7; i >= 0; i--) if (v[i]) r = 3'(i);
		return r;
	endfunction
	function automatic logic [2:0] hi1(input logic [7:0] v);
		logic [2:0] r;
		r = 3'd0;
		for (int i = 0; i < 8; i++) if (v[i]) r = 3'(i);
		return r;
	endfunction

	assign cmd_ready = st_q == S_IDLE;
	assign res_valid = st_q == S_OUT;
	assign res_data = res_q;

	logic fs_we, dm_we;
	logic [AW-1:0] fs_wa;
	logic [CW-1:0] dm_wa;
	logic [7:0] fs_wd, dm_wd;
	logic [CW-1:0] dm_ra;
	logic last_pg;
	assign last_pg = (32'(pg_q) == PAGES - 1) || (m8 == 8'd0 && (cmd_q.mask >>
		{pg_q, 3'b000}) == 64'd0);

	always_comb begin
		fs_we = 1'b0; fs_wa = addr; fs_wd = nw;
		dm_we = 1'b0; dm_wa = cidx; dm_wd = dm_rd_q | dacc_q;
		dm_ra = cidx;
		case (st_q)
			S_CLR: begin
				fs_we = 1'b1; fs_wa = clr_q; fs_wd = 8'd0;
				dm_we = 1'b1; dm_wa = clr_q[CW-1:0]; dm_wd = 8'd0;
			end
			S_WR: begin
				fs_we = m8 != 8'd0;
				dm_we = last_pg;
				dm_wd = dm_rd_q | dacc_q | ((nw != fs_rd_q && m8 != 8'd0) ?
					8'(1 << pg_q) : 8'd0);
			end
			S_SCAN, S_SWAIT, S_RUN: begin
				dm_ra = c_q[CW-1:0];
				if ((st_q == S_SWAIT || st_q == S_RUN) && dm_rd_q != 8'd0) begin
					dm_we = 1'b1; dm_wa = c_q[CW-1:0] - CW'(1); dm_wd = 8'd0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fs_we) fs_mem[fs_wa] <= fs_wd;
		fs_rd_q <= fs_mem[(st_q == S_BYTE) ? {cmd_q.page[PW-1:0], cidx} : addr];
		if (dm_we) dm_mem[dm_wa] <= dm_wd;
		dm_rd_q <= dm_mem[dm_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR;
			clr_q <= '0;
			cmd_q <= '0;
			pg_q <= '0;
			c_q <= '0;
			left_q <= '0;
			uni_q <= 8'd0;
			dacc_q <= 8'd0;
			res_q <= '0;
		end else begin
			case (st_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (&clr_q) st_q <= S_IDLE;
				end
				S_IDLE: if (cmd_valid) begin
					cmd_q <= cmd_data;
					pg_q <= '0;
					c_q <= '0;
					dacc_q <= 8'd0;
					uni_q <= 8'd0;
					res_q <= '0;
					if (cmd_data.bad) begin
						res_q.status <= cmd_data.kind == fbrop_pkg::REQ_DRAW;
						st_q <= S_OUT;
					end else if (cmd_data.kind == fbrop_pkg::REQ_DRAW) begin
						st_q <= (cmd_data.mask == 64'd0) ? S_OUT : S_RD;
					end else if (cmd_data.kind == fbrop_pkg::REQ_TAKE) begin
						st_q <= S_SCAN;
					end else begin
						st_q <= S_BYTE;
					end
				end
				S_RD: st_q <= S_WR;
				S_WR: begin
					if (nw != fs_rd_q && m8 != 8'd0) dacc_q <= dacc_q | 8'(1 << pg_q);
					if (last_pg) st_q <= S_OUT;
					else begin
						pg_q <= pg_q + PW'(1);
						st_q <= S_RD;
					end
				end
				S_SCAN: begin
					// address c_q issued; data next cycle
					c_q <= c_q + (CW+1)'(1);
					st_q <= S_SWAIT;
				end
				S_SWAIT: begin
					if (dm_rd_q != 8'd0) begin
						left_q <= CW'(c_q - (CW+1)'(1));
						uni_q <= dm_rd_q;
						if (32'(c_q) == WIDTH) begin
							res_q.run_found <= 1'b1;
							res_q.run_left <= 7'(c_q - (CW+1)'(1));
							res_q.run_right <= 7'(c_q - (CW+1)'(1));
							res_q.page_top <= lo1(dm_rd_q);
							res_q.page_bottom <= hi1(dm_rd_q);
							st_q <= S_OUT;
						end else begin
							c_q <= c_q + (CW+1)'(1);
							st_q <= S_RUN;
						end
					end else if (32'(c_q) == WIDTH) begin
						st_q <= S_OUT;
					end else begin
						c_q <= c_q + (CW+1)'(1);
					end
				end
				S_RUN: begin
					// dm_rd_q is mask at column c_q-1
					if (dm_rd_q != 8'd0) begin
						uni_q <= uni_q | dm_rd_q;
						if (32'(c_q) == WIDTH) begin
							res_q.run_found <= 1'b1;
							res_q.run_left <= 7'(left_q);
							res_q.run_right <= 7'(c_q - (CW+1)'(1));
							res_q.page_top <= lo1(uni_q | dm_rd_q);
							res_q.page_bottom <= hi1(uni_q | dm_rd_q);
							st_q <= S_OUT;
						end else c_q <= c_q + (CW+1)'(1);
					end else begin
						res_q.run_found <= 1'b1;
						res_q.run_left <= 7'(left_q);
						res_q.run_right <= 7'(c_q - (CW+1)'(2));
						res_q.page_top <= lo1(uni_q);
						res_q.page_bottom <= hi1(uni_q);
						st_q <= S_OUT;
					end
				end
				S_BYTE: st_q <= S_RDAT;
				S_RDAT: begin
					res_q.read_byte <= fs_rd_q;
					st_q <= S_OUT;
				end
				S_OUT: if (res_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/framebuffer_column_raster_op_dirty.sv =====
// Top level: page-organized monochrome frame store with dirty run tracking.
// Depends on fbrop_pkg, fbrop_if, fbrop_front, fbrop_back.
//
// One request gives one result. After reset a clearing pass over every
// store address zeroes the store and masks before requests are served. A
// draw steps through the pages from page 0 through the page after the last
// one it touches (or through the last page); rejected and zero-length draws
// go straight to the result. A take-run walks the dirty mask memory one
// column a cycle.
// A two-entry request queue lets new requests enter while the back end works.
module framebuffer_column_raster_op_dirty #(
	parameter int WIDTH  = 128,
	parameter int HEIGHT = 64
) (
	input logic clk,
	input logic arst_n,
	fbrop_if.sink   req,
	fbrop_if.source res
);
	logic cmd_valid, cmd_ready;
	fbrop_pkg::cmd_t cmd_data;

	fbrop_front #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_front (
		.clk, .arst_n,
		.in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
		.cmd_valid, .cmd_ready, .cmd_data
	);

	fbrop_back #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_back (
		.clk, .arst_n,
		.cmd_valid, .cmd_ready, .cmd_data,
		.res_valid(res.valid), .res_ready(res.ready), .res_data(res.data)
	);
endmodule

// ===== rtl/fbrop_checker.sv =====
// Port checker for the frame store block, bound to the top level.
// Depends on fbrop_pkg.
module fbrop_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            res_valid,
	input logic            res_ready,
	input fbrop_pkg::res_t res_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result dropped while stalled");
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.run_found |-> res_data.run_left <= res_data.run_right &&
		res_data.page_top <= res_data.page_bottom)
		else $error("bad run bounds");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.status |-> !res_data.run_found && res_data.read_byte == 8'd0)
		else $error("error result carries data");
endmodule

bind framebuffer_column_raster_op_dirty fbrop_checker u_chk (
	.clk, .arst_n, .res_valid(res.valid), .res_ready(res.ready), .res_data(res.data)
);
